>>> rtl/core/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared widths, pipeline depths, register indexes and flag type for the
// bump texture coordinate shift pipeline.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_LIGHT_X   = 3'd0;
  localparam logic [2:0] REG_LIGHT_Y   = 3'd1;
  localparam logic [2:0] REG_LIGHT_Z   = 3'd2;
  localparam logic [2:0] REG_TEXTURE_W = 3'd3;
  localparam logic [2:0] REG_TEXTURE_H = 3'd4;
  localparam logic [2:0] REG_SHIFT_EN  = 3'd5;

  // Arithmetic widths.
  localparam int L_W    = 33;  // light vector, Q16.16
  localparam int B_W    = 19;  // rounded binormal part, Q4.14
  localparam int S_W    = 50;  // T.L and N.L
  localparam int T_W    = 52;  // B.L
  localparam int MAG_W  = 51;  // magnitudes before scaling
  localparam int POS_W  = 6;   // leading one position
  localparam int NRM_W  = 30;  // scaled magnitudes
  localparam int SQ_W   = 61;  // sum of squares
  localparam int LEN_W  = 31;  // vector length
  localparam int SIZE_W = 14;  // texture size
  localparam int DEN_W  = 45;  // length times size
  localparam int NUM_W  = 47;  // rounded dividend
  localparam int Q_W    = 17;  // quotient

  // Pipeline depths of each unit.
  localparam int LAT_FRONT = 4;
  localparam int LAT_NORM  = 3;
  localparam int LAT_SQRT  = 2 + LEN_W;
  localparam int LAT_DIV   = 2 + Q_W;
  localparam int LAT_TOTAL = LAT_FRONT + LAT_NORM + LAT_SQRT + LAT_DIV + 1;

  typedef struct packed {
    logic kill;   // shift forced to zero
    logic s_neg;
    logic t_neg;
  } shift_flags_t;

endpackage

>>> rtl/core/bts_vtx_if.sv
// ----------------------------------------------------------------------------
// bts_vtx_if
// Vertex input channel: valid, ready and one vertex item.
// ----------------------------------------------------------------------------
interface bts_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic signed [31:0] tex_s_in;
  logic signed [31:0] tex_t_in;

  modport source (output valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y,
                  normal_z, tangent_x, tangent_y, tangent_z, tex_s_in, tex_t_in,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y,
                normal_z, tangent_x, tangent_y, tangent_z, tex_s_in, tex_t_in,
                output ready);
endinterface

>>> rtl/core/bts_res_if.sv
// ----------------------------------------------------------------------------
// bts_res_if
// Result channel: valid, ready and one shifted vertex item.
// ----------------------------------------------------------------------------
interface bts_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tex_s_out;
  logic signed [31:0] tex_t_out;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic signed [31:0] pos_z_out;

  modport source (output valid, tex_s_out, tex_t_out, pos_x_out, pos_y_out, pos_z_out,
                  input ready);
  modport sink (input valid, tex_s_out, tex_t_out, pos_x_out, pos_y_out, pos_z_out,
                output ready);
endinterface

>>> rtl/core/bts_cfg_if.sv
// ----------------------------------------------------------------------------
// bts_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface bts_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/bump_texcoord_shift.sv
// ----------------------------------------------------------------------------
// bump_texcoord_shift
// Emboss bump map texture coordinate shift, one vertex per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Each vertex item yields one result item: the texture coordinate moved
// against the light direction seen in tangent space, scaled by the texture
// size, and the position passed through. The block is a fully pipelined
// datapath that takes one item every clock while the output is not stalled;
// the depth is set by the bit-per-stage square root (33 stages with its
// squaring) and the bit-per-stage divider (19 stages), behind a 4-stage
// vector front end and a 3-stage scaling unit. All stages advance together
// whenever the output register is empty or being read, so the input stalls
// while a finished item waits until the consumer takes it, and a stall
// loses or repeats nothing. Configuration writes are taken on every cycle
// and must only be issued while no item is in flight. When shifting is
// disabled, the light lies below the surface, or the tangent space vector
// is zero, the coordinate passes unchanged (saturated to 32 bits, which
// never changes it).
// ----------------------------------------------------------------------------
module bump_texcoord_shift (
  input  logic  clk,
  input  logic  rst,
  bts_vtx_if.sink   vtx,
  bts_res_if.source res,
  bts_cfg_if.sink   cfg
);
  import bts_pkg::*;

  localparam int SIDE_D = LAT_TOTAL - 1;
  localparam int FLAG_D = LAT_SQRT + LAT_DIV;

  // Configuration registers.
  logic signed [31:0] light_x, light_y, light_z;
  logic [SIZE_W-1:0]  texture_w, texture_h;
  logic               shift_enable;

  // Global advance: the whole pipe moves when the output slot frees.
  logic                 en;
  logic [LAT_TOTAL-1:0] vld;

  assign en        = !vld[LAT_TOTAL-1] || res.ready;
  assign vtx.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x      <= '0;
      light_y      <= '0;
      light_z      <= '0;
      texture_w    <= SIZE_W'(256);
      texture_h    <= SIZE_W'(256);
      shift_enable <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LIGHT_X:   light_x      <= cfg.data;
        REG_LIGHT_Y:   light_y      <= cfg.data;
        REG_LIGHT_Z:   light_z      <= cfg.data;
        REG_TEXTURE_W: texture_w    <= cfg.data[SIZE_W-1:0];
        REG_TEXTURE_H: texture_h    <= cfg.data[SIZE_W-1:0];
        REG_SHIFT_EN:  shift_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT_TOTAL-2:0], vtx.valid};
    end
  end

  // Datapath units.
  logic signed [S_W-1:0] s4;
  logic signed [T_W-1:0] t4;
  logic                  r_neg4;
  logic [NRM_W-1:0]      ms_n, mt_n, ms_q, mt_q;
  shift_flags_t          flags_n;
  logic [LEN_W-1:0]      len;
  logic [Q_W-1:0]        q_s, q_t;

  bts_front u_front (
    .clk(clk), .en(en),
    .light_x(light_x), .light_y(light_y), .light_z(light_z),
    .vertex_x(vtx.vertex_x), .vertex_y(vtx.vertex_y), .vertex_z(vtx.vertex_z),
    .normal_x(vtx.normal_x), .normal_y(vtx.normal_y), .normal_z(vtx.normal_z),
    .tangent_x(vtx.tangent_x), .tangent_y(vtx.tangent_y), .tangent_z(vtx.tangent_z),
    .s(s4), .t(t4), .r_neg(r_neg4)
  );

  bts_norm u_norm (
    .clk(clk), .en(en), .s(s4), .t(t4), .r_neg(r_neg4),
    .ms_n(ms_n), .mt_n(mt_n), .flags(flags_n)
  );

  bts_sqrt u_sqrt (
    .clk(clk), .en(en), .ms(ms_n), .mt(mt_n),
    .len(len), .ms_o(ms_q), .mt_o(mt_q)
  );

  bts_div u_div_s (
    .clk(clk), .en(en), .m(ms_q), .len(len), .size(texture_w), .q(q_s)
  );

  bts_div u_div_t (
    .clk(clk), .en(en), .m(mt_q), .len(len), .size(texture_h), .q(q_t)
  );

  // Side data that rides along with each item: coordinates and position
  // from acceptance, shift flags from the scaling unit onward.
  logic signed [31:0] sd_s [SIDE_D];
  logic signed [31:0] sd_t [SIDE_D];
  logic signed [31:0] sd_x [SIDE_D];
  logic signed [31:0] sd_y [SIDE_D];
  logic signed [31:0] sd_z [SIDE_D];
  shift_flags_t       fd   [FLAG_D];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_s[0] <= vtx.tex_s_in;
      sd_t[0] <= vtx.tex_t_in;
      sd_x[0] <= vtx.vertex_x;
      sd_y[0] <= vtx.vertex_y;
      sd_z[0] <= vtx.vertex_z;
      for (int i = 1; i < SIDE_D; i++) begin
        sd_s[i] <= sd_s[i-1];
        sd_t[i] <= sd_t[i-1];
        sd_x[i] <= sd_x[i-1];
        sd_y[i] <= sd_y[i-1];
        sd_z[i] <= sd_z[i-1];
      end
      fd[0] <= flags_n;
      for (int i = 1; i < FLAG_D; i++) begin
        fd[i] <= fd[i-1];
      end
    end
  end

  // Final stage: signed shift, subtract and saturate into the output register.
  shift_flags_t          fl_last;
  logic                  zero_shift;
  logic signed [Q_W:0]   ds, dt;
  logic signed [33:0]    diff_s, diff_t;
  logic signed [31:0]    out_s, out_t, out_x, out_y, out_z;

  assign fl_last    = fd[FLAG_D-1];
  assign zero_shift = fl_last.kill || !shift_enable;
  assign ds = zero_shift ? '0 : (fl_last.s_neg ? -$signed({1'b0, q_s}) : $signed({1'b0, q_s}));
  assign dt = zero_shift ? '0 : (fl_last.t_neg ? -$signed({1'b0, q_t}) : $signed({1'b0, q_t}));
  assign diff_s = 34'(sd_s[SIDE_D-1]) - 34'(ds);
  assign diff_t = 34'(sd_t[SIDE_D-1]) - 34'(dt);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_s <= sat32(diff_s);
      out_t <= sat32(diff_t);
      out_x <= sd_x[SIDE_D-1];
      out_y <= sd_y[SIDE_D-1];
      out_z <= sd_z[SIDE_D-1];
    end
  end

  assign res.valid     = vld[LAT_TOTAL-1];
  assign res.tex_s_out = out_s;
  assign res.tex_t_out = out_t;
  assign res.pos_x_out = out_x;
  assign res.pos_y_out = out_y;
  assign res.pos_z_out = out_z;

  // An accepted item always occupies the first pipeline slot.
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    vtx.valid && vtx.ready |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  // While the output is stalled no item moves or vanishes.
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits changed during a stall");

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid after reset");

endmodule

>>> rtl/core/bts_front.sv
// ----------------------------------------------------------------------------
// bts_front
// Light vector, binormal and the dot products N.L, T.L and B.L (4 stages).
// ----------------------------------------------------------------------------
module bts_front (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [31:0]            light_x,
  input  logic signed [31:0]            light_y,
  input  logic signed [31:0]            light_z,
  input  logic signed [31:0]            vertex_x,
  input  logic signed [31:0]            vertex_y,
  input  logic signed [31:0]            vertex_z,
  input  logic signed [15:0]            normal_x,
  input  logic signed [15:0]            normal_y,
  input  logic signed [15:0]            normal_z,
  input  logic signed [15:0]            tangent_x,
  input  logic signed [15:0]            tangent_y,
  input  logic signed [15:0]            tangent_z,
  output logic signed [bts_pkg::S_W-1:0] s,
  output logic signed [bts_pkg::T_W-1:0] t,
  output logic                          r_neg
);
  import bts_pkg::*;

  // Stage 1
  logic signed [L_W-1:0] l1x, l1y, l1z;
  logic signed [15:0]    n1x, n1y, n1z, t1x, t1y, t1z;
  logic signed [31:0]    p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  // Stage 2
  logic signed [L_W-1:0] l2x, l2y, l2z;
  logic signed [B_W-1:0] bx, by, bz;
  logic signed [48:0]    nlx, nly, nlz, tlx, tly, tlz;
  // Stage 3
  logic signed [S_W-1:0] r3, s3;
  logic signed [T_W-1:0] blx, bly, blz;

  always_ff @(posedge clk) begin
    if (en) begin
      l1x  <= L_W'(light_x) - L_W'(vertex_x);
      l1y  <= L_W'(light_y) - L_W'(vertex_y);
      l1z  <= L_W'(light_z) - L_W'(vertex_z);
      n1x  <= normal_x;
      n1y  <= normal_y;
      n1z  <= normal_z;
      t1x  <= tangent_x;
      t1y  <= tangent_y;
      t1z  <= tangent_z;
      p_yz <= normal_y * tangent_z;
      p_zy <= normal_z * tangent_y;
      p_zx <= normal_z * tangent_x;
      p_xz <= normal_x * tangent_z;
      p_xy <= normal_x * tangent_y;
      p_yx <= normal_y * tangent_x;

      // Binormal parts rounded from Q4.28 to 14 fraction bits.
      bx  <= B_W'((34'(p_yz) - 34'(p_zy) + 34'sd8192) >>> 14);
      by  <= B_W'((34'(p_zx) - 34'(p_xz) + 34'sd8192) >>> 14);
      bz  <= B_W'((34'(p_xy) - 34'(p_yx) + 34'sd8192) >>> 14);
      nlx <= n1x * l1x;
      nly <= n1y * l1y;
      nlz <= n1z * l1z;
      tlx <= t1x * l1x;
      tly <= t1y * l1y;
      tlz <= t1z * l1z;
      l2x <= l1x;
      l2y <= l1y;
      l2z <= l1z;

      r3  <= S_W'(nlx) + S_W'(nly) + S_W'(nlz);
      s3  <= S_W'(tlx) + S_W'(tly) + S_W'(tlz);
      blx <= bx * l2x;
      bly <= by * l2y;
      blz <= bz * l2z;

      s     <= s3;
      t     <= blx + bly + blz;
      r_neg <= r3[S_W-1];
    end
  end

endmodule

>>> rtl/core/bts_norm.sv
// ----------------------------------------------------------------------------
// bts_norm
// Magnitudes of s and t scaled by one power of two so that the larger one
// has its leading one at bit 29 (3 stages).
// ----------------------------------------------------------------------------
module bts_norm (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [bts_pkg::S_W-1:0]   s,
  input  logic signed [bts_pkg::T_W-1:0]   t,
  input  logic                             r_neg,
  output logic [bts_pkg::NRM_W-1:0]        ms_n,
  output logic [bts_pkg::NRM_W-1:0]        mt_n,
  output bts_pkg::shift_flags_t            flags
);
  import bts_pkg::*;

  localparam logic [POS_W-1:0] TOP_POS = POS_W'(NRM_W - 1);

  logic [MAG_W-1:0] ms1, mt1, ms2, mt2, m1;
  shift_flags_t     fl1, fl2;
  logic [POS_W-1:0] pos_c, pos2;

  assign m1 = (ms1 > mt1) ? ms1 : mt1;

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m1[i]) pos_c = POS_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ms1       <= s[S_W-1] ? MAG_W'(-s) : MAG_W'(s);
      mt1       <= t[T_W-1] ? MAG_W'(-t) : MAG_W'(t);
      fl1.kill  <= r_neg;
      fl1.s_neg <= s[S_W-1];
      fl1.t_neg <= t[T_W-1];

      ms2       <= ms1;
      mt2       <= mt1;
      pos2      <= pos_c;
      // A zero vector also forces the shift to zero.
      fl2.kill  <= fl1.kill || (m1 == '0);
      fl2.s_neg <= fl1.s_neg;
      fl2.t_neg <= fl1.t_neg;

      // Right shifts truncate, left shifts fill with zeros.
      if (pos2 >= TOP_POS) begin
        ms_n <= NRM_W'(ms2 >> (pos2 - TOP_POS));
        mt_n <= NRM_W'(mt2 >> (pos2 - TOP_POS));
      end else begin
        ms_n <= NRM_W'(ms2 << (TOP_POS - pos2));
        mt_n <= NRM_W'(mt2 << (TOP_POS - pos2));
      end
      flags <= fl2;
    end
  end

endmodule

>>> rtl/core/bts_sqrt.sv
// ----------------------------------------------------------------------------
// bts_sqrt
// Vector length floor(sqrt(ms^2 + mt^2)): squares, sum, then one root bit
// per stage. The scaled magnitudes travel alongside.
// ----------------------------------------------------------------------------
module bts_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bts_pkg::NRM_W-1:0]  ms,
  input  logic [bts_pkg::NRM_W-1:0]  mt,
  output logic [bts_pkg::LEN_W-1:0]  len,
  output logic [bts_pkg::NRM_W-1:0]  ms_o,
  output logic [bts_pkg::NRM_W-1:0]  mt_o
);
  import bts_pkg::*;

  localparam int TW = 2 * LEN_W + 1;

  logic [2*NRM_W-1:0] sqs, sqt;
  logic [NRM_W-1:0]   ms1, mt1;
  logic [SQ_W-1:0]    rem  [LEN_W+1];
  logic [LEN_W-1:0]   root [LEN_W+1];
  logic [NRM_W-1:0]   msd  [LEN_W+1];
  logic [NRM_W-1:0]   mtd  [LEN_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sqs     <= ms * ms;
      sqt     <= mt * mt;
      ms1     <= ms;
      mt1     <= mt;
      rem[0]  <= SQ_W'(sqs) + SQ_W'(sqt);
      root[0] <= '0;
      msd[0]  <= ms1;
      mtd[0]  <= mt1;
    end
  end

  for (genvar k = 0; k < LEN_W; k++) begin : g_bit
    localparam int B = LEN_W - 1 - k;
    logic [TW-1:0] trial;
    assign trial = (TW'(root[k]) << (B + 1)) + (TW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (TW'(rem[k]) >= trial) begin
          rem[k+1]  <= rem[k] - SQ_W'(trial);
          root[k+1] <= root[k] | (LEN_W'(1) << B);
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k];
        end
        msd[k+1] <= msd[k];
        mtd[k+1] <= mtd[k];
      end
    end
  end

  assign len  = root[LEN_W];
  assign ms_o = msd[LEN_W];
  assign mt_o = mtd[LEN_W];

endmodule

>>> rtl/core/bts_div.sv
// ----------------------------------------------------------------------------
// bts_div
// Rounded quotient m * 65536 / (len * size), restoring division with one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module bts_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bts_pkg::NRM_W-1:0]   m,
  input  logic [bts_pkg::LEN_W-1:0]   len,
  input  logic [bts_pkg::SIZE_W-1:0]  size,
  output logic [bts_pkg::Q_W-1:0]     q
);
  import bts_pkg::*;

  localparam int CW = DEN_W + Q_W;

  logic [SIZE_W-1:0] size_eff;
  logic [DEN_W-1:0]  den1;
  logic [NRM_W-1:0]  m1;
  logic [NUM_W-1:0]  rem  [Q_W+1];
  logic [DEN_W-1:0]  den  [Q_W+1];
  logic [Q_W-1:0]    quo  [Q_W+1];

  // A size of zero counts as one.
  assign size_eff = (size == '0) ? SIZE_W'(1) : size;

  always_ff @(posedge clk) begin
    if (en) begin
      den1   <= len * size_eff;
      m1     <= m;
      rem[0] <= NUM_W'({m1, 16'b0}) + NUM_W'(den1 >> 1);
      den[0] <= den1;
      quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    localparam int B = Q_W - 1 - k;
    logic [CW-1:0] cmp;
    assign cmp = CW'(den[k]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (CW'(rem[k]) >= cmp) begin
          rem[k+1] <= rem[k] - NUM_W'(cmp);
          quo[k+1] <= {quo[k][Q_W-2:0], 1'b1};
        end else begin
          rem[k+1] <= rem[k];
          quo[k+1] <= {quo[k][Q_W-2:0], 1'b0};
        end
        den[k+1] <= den[k];
      end
    end
  end

  assign q = quo[Q_W];

endmodule
